>>> src/mcrs_pkg.sv
// Shared constants, request codes, sequencer states and coordinate helper.
package mcrs_pkg;

  localparam int unsigned MAX_CITIES = 1024;
  localparam int unsigned MAX_TOWERS = 1024;
  localparam int unsigned COORD_BITS = 32;

  // Port field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned RADIUS_W = 32;
  localparam int unsigned REQ_W    = 2;

  // Coordinates keep at most 32 significant bits
  localparam int unsigned COORD_EFF = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int unsigned EXT_SHIFT = COORD_W - COORD_EFF;

  localparam int unsigned CITY_AW  = $clog2(MAX_CITIES);
  localparam int unsigned CITY_CW  = $clog2(MAX_CITIES + 1);
  localparam int unsigned TOWER_AW = $clog2(MAX_TOWERS);
  localparam int unsigned TOWER_CW = $clog2(MAX_TOWERS + 1);

  // Upper bound of the search: 2^COORD_EFF - 1
  localparam logic [RADIUS_W-1:0] SEARCH_HI =
    RADIUS_W'((64'd1 << COORD_EFF) - 64'd1);

  typedef enum logic [REQ_W-1:0] {
    REQ_CITY    = 2'd0,
    REQ_TOWER   = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_FETCH,
    ST_DIST,
    ST_CMP,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  // Take the low COORD_EFF bits as a two's complement value
  function automatic logic signed [COORD_W-1:0] to_coord(input logic [COORD_W-1:0] raw);
    logic [COORD_W-1:0] v;
    v = raw << EXT_SHIFT;
    return $signed(v) >>> EXT_SHIFT;
  endfunction

endpackage

>>> src/mcrs_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module mcrs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/min_coverage_radius_search.sv
// Minimum coverage radius search: load cities and towers, then binary-search the radius.
// Sequence: a compute word goes straight to the result when either store is empty; else each
//   probe walks up to cities + towers - 1 steps through ST_FETCH, ST_DIST and ST_CMP.
// Throughput: one word per cycle for loads while the sequencer is idle; one compute at a time,
//   set by the single distance/compare unit walking both store RAMs.
// Reset: asynchronous, active low; clears counts, sequencer and output valid; store
//   contents stay undefined until written.
module min_coverage_radius_search
  import mcrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input words
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [COORD_W-1:0]  s_axis_tdata_i,   // [31:0] coord
  input  logic [REQ_W-1:0]    s_axis_tuser_i,   // [1:0] req_type
  // Result words
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [RADIUS_W-1:0] m_axis_tdata_o,   // [31:0] radius
  output logic                m_axis_tuser_o    // [0] uncoverable
);

  state_e state_q, state_d;

  logic [CITY_CW-1:0]  city_cnt_q;
  logic [TOWER_CW-1:0] tower_cnt_q;

  // Search bounds, probe radius and walk pointers
  logic [RADIUS_W-1:0] lo_q, hi_q, mid_q;
  logic [CITY_CW-1:0]  i_q;
  logic [TOWER_CW-1:0] j_q;
  logic [RADIUS_W-1:0] dist_q;

  logic                m_valid_q;
  logic [RADIUS_W-1:0] m_data_q;
  logic                m_user_q;

  logic [COORD_W-1:0]  city_rdata, tower_rdata;

  logic s_accept;
  logic is_city, is_tower, is_compute;
  logic city_we, tower_we;
  logic any_empty;
  logic probe_hit;
  logic walk_done;
  logic out_load;

  logic [CITY_CW-1:0]  i_inc;
  logic [TOWER_CW-1:0] j_inc;

  logic signed [COORD_W:0] diff_ct, diff_tc;

  assign s_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_city    = (s_axis_tuser_i == REQ_CITY);
  assign is_tower   = (s_axis_tuser_i == REQ_TOWER);
  assign is_compute = (s_axis_tuser_i == REQ_COMPUTE);

  // Drop loads into a full store
  assign city_we  = s_accept && is_city  && (city_cnt_q  < CITY_CW'(MAX_CITIES));
  assign tower_we = s_accept && is_tower && (tower_cnt_q < TOWER_CW'(MAX_TOWERS));

  assign any_empty = (city_cnt_q == '0) || (tower_cnt_q == '0);

  assign i_inc = i_q + CITY_CW'(1);
  assign j_inc = j_q + TOWER_CW'(1);

  // Distance unit: both differences in parallel, keep the non-negative one
  assign diff_ct = $signed({city_rdata[COORD_W-1], city_rdata})
                 - $signed({tower_rdata[COORD_W-1], tower_rdata});
  assign diff_tc = $signed({tower_rdata[COORD_W-1], tower_rdata})
                 - $signed({city_rdata[COORD_W-1], city_rdata});

  mcrs_ram #(
    .DEPTH (MAX_CITIES),
    .WIDTH (COORD_W)
  ) u_city_ram (
    .clk_i   (clk_i),
    .we_i    (city_we),
    .waddr_i (city_cnt_q[CITY_AW-1:0]),
    .wdata_i (to_coord(s_axis_tdata_i)),
    .raddr_i (i_q[CITY_AW-1:0]),
    .rdata_o (city_rdata)
  );

  mcrs_ram #(
    .DEPTH (MAX_TOWERS),
    .WIDTH (COORD_W)
  ) u_tower_ram (
    .clk_i   (clk_i),
    .we_i    (tower_we),
    .waddr_i (tower_cnt_q[TOWER_AW-1:0]),
    .wdata_i (to_coord(s_axis_tdata_i)),
    .raddr_i (j_q[TOWER_AW-1:0]),
    .rdata_o (tower_rdata)
  );

  // Sequencer outputs
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    probe_hit       = (dist_q <= mid_q);
    out_load        = (state_q == ST_FINISH) && (!m_valid_q || m_axis_tready_i);
    // Walk ends once either pointer steps past the last loaded entry
    walk_done       = probe_hit ? (i_inc == city_cnt_q) : (j_inc == tower_cnt_q);
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && is_compute) begin
          state_d = any_empty ? ST_FINISH : ST_MID;
        end
      end
      ST_MID: begin
        state_d = (lo_q < hi_q) ? ST_FETCH : ST_FINISH;
      end
      ST_FETCH:  state_d = ST_DIST;
      ST_DIST:   state_d = ST_CMP;
      ST_CMP: begin
        state_d = walk_done ? ST_UPDATE : ST_FETCH;
      end
      ST_UPDATE: state_d = ST_MID;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      city_cnt_q  <= '0;
      tower_cnt_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        // Clear both lists once the result is issued
        city_cnt_q  <= '0;
        tower_cnt_q <= '0;
      end else begin
        if (city_we) begin
          city_cnt_q <= city_cnt_q + CITY_CW'(1);
        end
        if (tower_we) begin
          tower_cnt_q <= tower_cnt_q + TOWER_CW'(1);
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        lo_q <= '0;
        hi_q <= SEARCH_HI;
      end
      ST_MID: begin
        // Probe the midpoint and restart the walk at the head of both lists
        mid_q <= lo_q + ((hi_q - lo_q) >> 1);
        i_q   <= '0;
        j_q   <= '0;
      end
      ST_DIST: begin
        dist_q <= diff_ct[COORD_W] ? diff_tc[COORD_W-1:0] : diff_ct[COORD_W-1:0];
      end
      ST_CMP: begin
        // Covered: advance to the next city; otherwise advance to the next tower
        if (probe_hit) begin
          i_q <= i_inc;
        end else begin
          j_q <= j_inc;
        end
      end
      ST_UPDATE: begin
        if (i_q == city_cnt_q) begin
          hi_q <= mid_q;
        end else begin
          lo_q <= mid_q + RADIUS_W'(1);
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      if (city_cnt_q == '0) begin
        m_data_q <= '0;
        m_user_q <= 1'b0;
      end else if (tower_cnt_q == '0) begin
        m_data_q <= '1;
        m_user_q <= 1'b1;
      end else begin
        m_data_q <= lo_q;
        m_user_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

>>> verif/min_coverage_radius_checker.sv
`timescale 1ns / 1ps
// Checker for the coverage radius search: tracks both coordinate lists, predicts and compares results.
module min_coverage_radius_checker
  import mcrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [COORD_W-1:0]  s_tdata_i,
  input  logic [REQ_W-1:0]    s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [RADIUS_W-1:0] m_tdata_i,
  input  logic                m_tuser_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic                uncoverable;
  } coverage_t;

  longint      city_pos [MAX_CITIES];
  longint      tower_pos[MAX_TOWERS];
  int unsigned n_city;
  int unsigned n_tower;
  coverage_t   radius_q[$];
  int          fails;

  // Greedy walk: true when every city lies within r of some tower.
  function automatic bit radius_covers(input longint unsigned r);
    int unsigned      i;
    int unsigned      j;
    int unsigned      hit;
    longint           diff;
    longint unsigned  abs_diff;
    i   = 0;
    j   = 0;
    hit = 0;
    while (i < n_city && j < n_tower) begin
      diff     = city_pos[i] - tower_pos[j];
      abs_diff = (diff < 0) ? longint'(-diff) : diff;
      if (abs_diff <= r) begin
        hit++;
        i++;
      end else begin
        j++;
      end
    end
    return hit == n_city;
  endfunction

  function automatic coverage_t predict_radius();
    coverage_t       res;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    res = '0;
    if (n_city == 0) begin
      res.radius = '0;
    end else if (n_tower == 0) begin
      res.radius      = '1;
      res.uncoverable = 1'b1;
    end else begin
      lo = 0;
      hi = (64'd1 << COORD_EFF) - 64'd1;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (radius_covers(mid)) hi = mid;
        else lo = mid + 1;
      end
      res.radius = lo[RADIUS_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coverage_t exp_res;
    if (!rst_ni) begin
      n_city  = 0;
      n_tower = 0;
      radius_q.delete();
      fails   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Retire results first: a compute taken on this edge cannot finish on it.
      if (m_tvalid_i && m_tready_i) begin
        if (radius_q.size() == 0) begin
          $display("%0t: unexpected result word, radius %h uncoverable %b",
                   $time, m_tdata_i, m_tuser_i);
          fails++;
        end else begin
          exp_res = radius_q.pop_front();
          if (m_tdata_i !== exp_res.radius) begin
            $display("%0t: radius mismatch, expected %h actual %h",
                     $time, exp_res.radius, m_tdata_i);
            fails++;
          end
          if (m_tuser_i !== exp_res.uncoverable) begin
            $display("%0t: uncoverable mismatch, expected %b actual %b",
                     $time, exp_res.uncoverable, m_tuser_i);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        case (s_tuser_i)
          REQ_CITY: begin
            // Full store drops the word.
            if (n_city < MAX_CITIES) begin
              city_pos[n_city] = longint'($signed(s_tdata_i));
              n_city++;
            end
          end
          REQ_TOWER: begin
            if (n_tower < MAX_TOWERS) begin
              tower_pos[n_tower] = longint'($signed(s_tdata_i));
              n_tower++;
            end
          end
          REQ_COMPUTE: begin
            radius_q.push_back(predict_radius());
            n_city  = 0;
            n_tower = 0;
          end
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= radius_q.size();
    end
  end

endmodule

>>> verif/min_coverage_radius_search_test.sv
`timescale 1ns / 1ps
// Testbench top for the coverage radius search: clock, reset, stimulus and verdict.
module min_coverage_radius_search_test;
  import mcrs_pkg::*;

  // Code outside the request set; the block must drop such words.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;

  // Random phase stops after this many load or compute words.
  localparam int RANDOM_WORDS = 200;
  // A full-store compute walks ~1k steps for each probe of the search; the limit
  // leaves wide room for that with no word moving on either side.
  localparam int IDLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [COORD_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]    s_tuser = REQ_CITY;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RADIUS_W-1:0] m_tdata;
  logic                m_tuser;

  int       fail_count;
  int       pending;
  int       idle_cycles = 0;
  int       burst_left = 0;
  int       loaded_words = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_hold = 0;
  int       city_q[$];
  int       tower_q[$];

  always #10 clk_i = ~clk_i;

  min_coverage_radius_search u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),    // [31:0] coord
    .s_axis_tuser_i  (s_tuser),    // [1:0] req_type
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),    // [31:0] radius
    .m_axis_tuser_o  (m_tuser)     // [0] uncoverable
  );

  min_coverage_radius_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver backpressure: switch between open, coin-flip, sparse and mostly-ready
  // stretches of random length so stalls land on every part of the result handshake.
  always @(posedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_hold <= $urandom_range(8, 200);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
      default:   m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one word and hold it until taken, then maybe open a gap before the next.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] coord);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= coord;
    s_tuser  <= req;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (req != REQ_UNKNOWN) loaded_words++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and hold off until every outstanding result has been taken.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Either full-range values or a tight cluster around a base, with extremes mixed in.
  function automatic int pick_coord(input bit narrow, input int base);
    case ($urandom_range(0, 31))
      0:       return int'(COORD_MIN);
      1:       return int'(COORD_MAX);
      2:       return 0;
      3:       return -1;
      default: return narrow ? base + $urandom_range(0, 40) - 20 : int'($urandom);
    endcase
  endfunction

  task automatic build_lists(input int unsigned n_c, input int unsigned n_t,
                             input bit sorted_lists);
    bit narrow;
    int base;
    narrow = $urandom_range(0, 1);
    base   = $urandom;
    city_q.delete();
    tower_q.delete();
    repeat (n_c) city_q.push_back(pick_coord(narrow, base));
    repeat (n_t) tower_q.push_back(pick_coord(narrow, base));
    if (sorted_lists) begin
      city_q.sort();
      tower_q.sort();
    end
  endtask

  // Interleave the two lists at random; each list keeps its own order.
  task automatic stream_lists(input bit noisy);
    while (city_q.size() + tower_q.size() > 0) begin
      if (noisy && $urandom_range(0, 9) == 0) send_word(REQ_UNKNOWN, $urandom);
      if (tower_q.size() == 0 || (city_q.size() != 0 && $urandom_range(0, 1)))
        send_word(REQ_CITY, city_q.pop_front());
      else
        send_word(REQ_TOWER, tower_q.pop_front());
    end
  endtask

  initial begin
    int pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty lists
    send_word(REQ_COMPUTE, '0);
    // Towers but no cities: radius 0
    send_word(REQ_TOWER, 32'd5);
    send_word(REQ_COMPUTE, '1);
    // Cities but no towers, with an unknown code in between
    send_word(REQ_CITY, 32'd0);
    send_word(REQ_CITY, 32'd7);
    send_word(REQ_UNKNOWN, 32'hA5A5_5A5A);
    send_word(REQ_COMPUTE, '0);
    // Widest distance: the answer is the top of the search range
    send_word(REQ_CITY, COORD_MIN);
    send_word(REQ_TOWER, COORD_MAX);
    send_word(REQ_COMPUTE, '0);
    // Two cities at the top, nearest tower at zero
    send_word(REQ_CITY, COORD_MAX);
    send_word(REQ_CITY, COORD_MAX);
    send_word(REQ_TOWER, COORD_MIN);
    send_word(REQ_TOWER, 32'd0);
    send_word(REQ_COMPUTE, '0);
    // Unsorted cities
    send_word(REQ_CITY, 32'd100);
    send_word(REQ_CITY, -32'sd100);
    send_word(REQ_TOWER, 32'd0);
    send_word(REQ_TOWER, 32'd50);
    send_word(REQ_COMPUTE, '0);
    // Coincident city and tower: radius 0
    send_word(REQ_CITY, '1);
    send_word(REQ_TOWER, '1);
    send_word(REQ_COMPUTE, '0);
    wait_for_results();

    // Store full: surplus loads past the depth must be dropped; fill one store per run
    if ($urandom_range(0, 1)) begin
      build_lists(MAX_CITIES + 4, 2, 1'b1);
    end else begin
      build_lists(2, MAX_TOWERS + 4, 1'b1);
    end
    stream_lists(1'b0);
    send_word(REQ_COMPUTE, $urandom);

    // Random: mostly sorted lists, some unsorted, some raw noise
    loaded_words = 0;
    while (loaded_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 8) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 92) begin
        build_lists($urandom_range(0, 8), $urandom_range(0, 8), pick < 78);
        stream_lists($urandom_range(0, 3) == 0);
        send_word(REQ_COMPUTE, $urandom);
      end else begin
        repeat ($urandom_range(1, 6)) send_word(REQ_W'($urandom_range(0, 3)), $urandom);
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
